### rtl/core/ntc_pkg.sv
// ----------------------------------------------------------------------------
// NTC divider to temperature: shared package
// Constants, register map, status codes and types for the NTC temperature core.
// ----------------------------------------------------------------------------
package ntc_pkg;

	localparam int unsigned DEF_SAMPLE_BITS = 12;
	localparam int unsigned REF_MV          = 3300;
	localparam int unsigned LOG_FRAC_BITS   = 28;
	localparam longint unsigned LN2_Q30     = 744261118;
	localparam longint unsigned BETA_DEN_SCALE = 1677721600;
	localparam longint unsigned BETA_NUM_SCALE = 2981500;
	localparam int unsigned T0_CENTI_K      = 29815;
	localparam int unsigned ZERO_C_CENTI_K  = 27315;
	localparam int unsigned Q_MAX           = 32767 + 27315;
	localparam int unsigned DIV_STEPS       = 18;

	localparam logic signed [15:0] OUT_MAX = 16'sd32767;
	localparam logic signed [15:0] OUT_MIN = -16'sd27315;

	localparam logic [19:0] RST_SERIES  = 20'd10000;
	localparam logic [19:0] RST_NOMINAL = 20'd10000;
	localparam logic [14:0] RST_BETA    = 15'd3950;
	localparam logic        RST_MODE    = 1'b1;

	typedef enum logic [1:0] {
		REG_SERIES,
		REG_NOMINAL,
		REG_BETA,
		REG_MODE
	} ntc_reg_t;

	typedef enum logic [1:0] {
		STS_VALID,
		STS_RANGE,
		STS_SAT
	} ntc_status_t;

endpackage

### rtl/core/ntc_sample_if.sv
// ----------------------------------------------------------------------------
// NTC sample channel
// Valid/ready channel that carries one sensor sample per beat.
// ----------------------------------------------------------------------------
interface ntc_sample_if #(
	parameter int unsigned SAMPLE_BITS = ntc_pkg::DEF_SAMPLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

### rtl/core/ntc_result_if.sv
// ----------------------------------------------------------------------------
// NTC result channel
// Valid/ready channel that carries one temperature and status per beat.
// ----------------------------------------------------------------------------
interface ntc_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temperature_centi_c;
	logic [1:0]         status;

	modport source (output valid, output temperature_centi_c, output status, input ready);
	modport sink (input valid, input temperature_centi_c, input status, output ready);
endinterface

### rtl/core/ntc_divider_to_temperature_top.sv
// ----------------------------------------------------------------------------
// NTC divider to temperature
// Converts a divider sample to degrees C in hundredths with the Beta equation.
//
//  channel   dir  beat contents
//  samples   in   sample
//  results   out  temperature_centi_c, status
//  apb       in   register writes and reads, no wait states
//
// The pipeline is 56 stages deep; one beat enters per cycle while the last
// stage is empty or its result is taken. The depth is set by the 28 squaring
// stages of each log2 lane and the 18 restoring division stages.
// Reset clears the valid bits and restores the register defaults.
// When the output beat is not taken, the whole pipeline holds.
// ----------------------------------------------------------------------------
module ntc_divider_to_temperature_top #(
	parameter int unsigned SAMPLE_BITS = ntc_pkg::DEF_SAMPLE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	ntc_sample_if.sink          samples,
	ntc_result_if.source        results
);
	import ntc_pkg::*;

	localparam int unsigned XW     = SAMPLE_BITS + 12;
	localparam logic [XW-1:0] FULL = XW'((1 << SAMPLE_BITS) - 1);
	localparam int unsigned MVW    = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
	localparam int unsigned LGN    = LOG_FRAC_BITS + 1;
	localparam int unsigned ST_LG0 = 2;
	localparam int unsigned ST_DIV0 = ST_LG0 + LGN + 5;
	localparam int unsigned NST    = ST_DIV0 + DIV_STEPS + 2;

	logic [19:0] series_q;
	logic [19:0] nominal_q;
	logic [14:0] beta_q;
	logic        mode_q;
	logic        wr_en;
	logic        en;

	logic [NST-1:0] vld_q;
	logic [NST-2:0] oor_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q  <= RST_SERIES;
			nominal_q <= RST_NOMINAL;
			beta_q    <= RST_BETA;
			mode_q    <= RST_MODE;
		end else if (wr_en) begin
			unique case (ntc_reg_t'(paddr[3:2]))
				REG_SERIES:  series_q  <= pwdata[19:0];
				REG_NOMINAL: nominal_q <= pwdata[19:0];
				REG_BETA:    beta_q    <= pwdata[14:0];
				REG_MODE:    mode_q    <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (ntc_reg_t'(paddr[3:2]))
			REG_SERIES:  prdata = {12'd0, series_q};
			REG_NOMINAL: prdata = {12'd0, nominal_q};
			REG_BETA:    prdata = {17'd0, beta_q};
			REG_MODE:    prdata = {31'd0, mode_q};
		endcase
	end

	assign en            = !vld_q[NST-1] || results.ready;
	assign samples.ready = en;

	// Raw code to millivolts: fold the quotient by 2^n - 1 with shifts and adds.
	logic [XW-1:0]  prod_x;
	logic [XW-1:0]  fold_t;
	logic [XW-1:0]  fold_q;
	logic [MVW-1:0] mv_full;
	logic           oor_in;

	always_comb begin
		prod_x = XW'(samples.sample) * XW'(REF_MV);
		fold_q = '0;
		fold_t = prod_x;
		for (int i = 0; i < 4; i++) begin
			fold_q = fold_q + (fold_t >> SAMPLE_BITS);
			fold_t = (fold_t >> SAMPLE_BITS) + (fold_t & FULL);
		end
		if (fold_t >= FULL) begin
			fold_q = fold_q + XW'(1);
		end
		mv_full = mode_q ? MVW'(fold_q) : MVW'(samples.sample);
		oor_in  = (mv_full == '0) || (mv_full >= MVW'(REF_MV));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], samples.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_q <= {oor_q[NST-3:0], oor_in};
		end
	end

	logic [11:0] mv_s1;
	logic [31:0] num_s2;
	logic [31:0] den_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s1  <= oor_in ? 12'd0 : mv_full[11:0];
			num_s2 <= 32'(series_q) * 32'(mv_s1);
			den_s2 <= 32'(nominal_q) * 32'(12'(REF_MV) - mv_s1);
		end
	end

	function automatic logic [4:0] lead_one(input logic [31:0] x);
		logic [4:0] top;
		top = '0;
		for (int k = 0; k < 32; k++) begin
			if (x[k]) begin
				top = 5'(k);
			end
		end
		return top;
	endfunction

	// Two log2 lanes: lane 0 for the numerator, lane 1 for the denominator.
	logic [31:0]              lg_y_sl   [2][LGN];
	logic [4:0]               lg_top_sl [2][LGN];
	logic [LOG_FRAC_BITS-1:0] lg_frac_sl[2][LGN];
	logic [4:0]               top_n;
	logic [4:0]               top_d;

	assign top_n = lead_one(num_s2);
	assign top_d = lead_one(den_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			lg_top_sl[0][0]  <= top_n;
			lg_y_sl[0][0]    <= num_s2 << (5'd31 - top_n);
			lg_frac_sl[0][0] <= '0;
			lg_top_sl[1][0]  <= top_d;
			lg_y_sl[1][0]    <= den_s2 << (5'd31 - top_d);
			lg_frac_sl[1][0] <= '0;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar j = 0; j < LOG_FRAC_BITS; j++) begin : g_sq
			logic [63:0] sq;
			assign sq = 64'(lg_y_sl[l][j]) * 64'(lg_y_sl[l][j]);
			always_ff @(posedge clk) begin
				if (en) begin
					lg_y_sl[l][j+1]    <= sq[63] ? sq[63:32] : sq[62:31];
					lg_frac_sl[l][j+1] <= {lg_frac_sl[l][j][LOG_FRAC_BITS-2:0], sq[63]};
					lg_top_sl[l][j+1]  <= lg_top_sl[l][j];
				end
			end
		end
	end

	logic [33:0] dl;
	logic [32:0] mag_sd;
	logic        neg_sd;
	logic [46:0] pp_lo_sp;
	logic [45:0] pp_hi_sp;
	logic        neg_sp;
	logic [63:0] lsum;
	logic signed [30:0] lq_sl;
	logic [45:0] t1_sm;
	logic signed [46:0] t2_sm;
	logic [36:0] nqb_sm;
	logic signed [47:0] dq_sa;
	logic [36:0] nqb_sa;

	assign dl = {1'b0, lg_top_sl[0][LGN-1], lg_frac_sl[0][LGN-1]}
	          - {1'b0, lg_top_sl[1][LGN-1], lg_frac_sl[1][LGN-1]};
	assign lsum = 64'(pp_lo_sp) + (64'(pp_hi_sp) << 17) + (64'(1) << 33);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_sd   <= dl[33];
			mag_sd   <= dl[33] ? 33'(-dl) : dl[32:0];
			pp_lo_sp <= 47'(mag_sd[16:0]) * 47'(LN2_Q30);
			pp_hi_sp <= 46'(mag_sd[32:17]) * 46'(LN2_Q30);
			neg_sp   <= neg_sd;
			lq_sl    <= neg_sp ? -$signed({1'b0, lsum[63:34]}) : $signed({1'b0, lsum[63:34]});
			t1_sm    <= 46'(beta_q) * 46'(BETA_DEN_SCALE);
			t2_sm    <= 47'(lq_sl) * 47'(signed'(T0_CENTI_K));
			nqb_sm   <= 37'(beta_q) * 37'(BETA_NUM_SCALE);
			dq_sa    <= $signed({2'b00, t1_sm}) + 48'(t2_sm);
			nqb_sa   <= nqb_sm;
		end
	end

	// Restoring division, one quotient bit per stage, top bit flags overflow.
	logic [61:0]          rem_sv [DIV_STEPS+1];
	logic [46:0]          dv_sv  [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] quo_sv [DIV_STEPS+1];
	logic                 dz_sv  [DIV_STEPS+1];
	logic                 dneg_sv[DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sv[0]  <= 62'({nqb_sa, 24'd0}) + 62'(dq_sa[46:1]);
			dv_sv[0]   <= dq_sa[46:0];
			quo_sv[0]  <= '0;
			dz_sv[0]   <= (dq_sa == '0);
			dneg_sv[0] <= dq_sa[47];
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [64:0] shd;
		logic        ge;
		assign shd = 65'(dv_sv[j]) << (DIV_STEPS - 1 - j);
		assign ge  = 65'(rem_sv[j]) >= shd;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sv[j+1]  <= ge ? rem_sv[j] - shd[61:0] : rem_sv[j];
				quo_sv[j+1]  <= {quo_sv[j][DIV_STEPS-2:0], ge};
				dv_sv[j+1]   <= dv_sv[j];
				dz_sv[j+1]   <= dz_sv[j];
				dneg_sv[j+1] <= dneg_sv[j];
			end
		end
	end

	logic [DIV_STEPS-1:0] qf;
	logic                 cfg_bad;
	logic                 too_hot;
	logic signed [15:0]   temp_nx;
	ntc_status_t          sts_nx;
	logic signed [15:0]   temp_so;
	ntc_status_t          sts_so;

	assign qf      = quo_sv[DIV_STEPS];
	assign cfg_bad = (series_q == '0) || (nominal_q == '0) || (beta_q == '0);
	assign too_hot = qf[DIV_STEPS-1] || (qf[DIV_STEPS-2:0] > (DIV_STEPS-1)'(Q_MAX));

	always_comb begin
		priority if (oor_q[NST-2]) begin
			temp_nx = '0;
			sts_nx  = STS_RANGE;
		end else if (cfg_bad || dneg_sv[DIV_STEPS]) begin
			temp_nx = OUT_MIN;
			sts_nx  = STS_SAT;
		end else if (dz_sv[DIV_STEPS] || too_hot) begin
			temp_nx = OUT_MAX;
			sts_nx  = STS_SAT;
		end else begin
			temp_nx = 16'(qf[DIV_STEPS-2:0] - (DIV_STEPS-1)'(ZERO_C_CENTI_K));
			sts_nx  = STS_VALID;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_so <= temp_nx;
			sts_so  <= sts_nx;
		end
	end

	assign results.valid               = vld_q[NST-1];
	assign results.temperature_centi_c = temp_so;
	assign results.status              = sts_so;

endmodule

### rtl/core/ntc_chk.sv
// ----------------------------------------------------------------------------
// NTC divider to temperature: port checker
// Assertions on the result channel of the temperature core, bound to its top.
// ----------------------------------------------------------------------------
module ntc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_temp,
	input logic [1:0]  out_status
);
	import ntc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_temp) && $stable(out_status))
		else $error("result beat changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status == STS_VALID || out_status == STS_RANGE
		|| out_status == STS_SAT)
		else $error("undefined status code");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == STS_RANGE |-> out_temp == 16'd0)
		else $error("out of range beat with nonzero temperature");

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == STS_VALID |-> $signed(out_temp) >= OUT_MIN)
		else $error("valid temperature below absolute zero");

	a_rst: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result beat during reset");

endmodule

bind ntc_divider_to_temperature_top ntc_chk u_ntc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_temp   (results.temperature_centi_c),
	.out_status (results.status)
);
